// ===== rtl/fpm_pkg.sv =====
package fpm_pkg;

  // Default configuration
  localparam int DEF_MAX_TERMS = 32;
  localparam int DEF_COEF_BITS = 12;

  // Result field widths
  localparam int PROD_W      = 29;
  localparam int DEG_W       = 6;
  localparam int OUT_TDATA_W = ((PROD_W + DEG_W + 7) / 8) * 8;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;   // a coefficient pair is written this cycle
    logic clear;  // first pair of a run: other cells drop their old terms
    logic step;   // advance the chain by one output coefficient
  } cell_ctl_t;

endpackage

// ===== rtl/fpm_cell.sv =====
module fpm_cell #(
  parameter int COEF_BITS = fpm_pkg::DEF_COEF_BITS
) (
  input  logic                                clk_i,
  input  fpm_pkg::cell_ctl_t                  ctl_i,
  input  logic                                sel_i,
  input  logic signed [COEF_BITS-1:0]         coef_a_i,
  input  logic signed [COEF_BITS-1:0]         coef_b_i,
  input  logic signed [COEF_BITS-1:0]         x_i,
  input  logic signed [COEF_BITS-1:0]         b_next_i,
  input  logic signed [fpm_pkg::PROD_W-1:0]   s_next_i,
  output logic signed [COEF_BITS-1:0]         b_o,
  output logic signed [fpm_pkg::PROD_W-1:0]   s_o,
  output logic signed [fpm_pkg::PROD_W-1:0]   sum_o
);
  import fpm_pkg::*;

  logic signed [COEF_BITS-1:0]   a_q;
  logic signed [COEF_BITS-1:0]   b_q;
  logic signed [PROD_W-1:0]      s_q;
  logic signed [2*COEF_BITS-1:0] prod;

  // Tap product plus partial sum from the right-hand neighbor (mod 2^PROD_W)
  assign prod  = a_q * x_i;
  assign sum_o = PROD_W'(prod) + s_next_i;

  // Stationary coefficient of the first polynomial
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      if (sel_i) begin
        a_q <= coef_a_i;
      end else if (ctl_i.clear) begin
        a_q <= '0;
      end
    end
  end

  // Second polynomial: loaded in place, then shifted toward cell 0
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      if (sel_i) begin
        b_q <= coef_b_i;
      end else if (ctl_i.clear) begin
        b_q <= '0;
      end
    end else if (ctl_i.step) begin
      b_q <= b_next_i;
    end
  end

  // Partial sum, handed to the left-hand neighbor
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      s_q <= '0;
    end else if (ctl_i.step) begin
      s_q <= sum_o;
    end
  end

  assign b_o = b_q;
  assign s_o = s_q;

endmodule

// ===== rtl/fpm_ctrl.sv =====
module fpm_ctrl #(
  parameter int MAX_TERMS = fpm_pkg::DEF_MAX_TERMS,
  parameter int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               last_term_i,
  input  logic                               out_ready_i,
  input  logic signed [fpm_pkg::PROD_W-1:0]  sum_i,
  output fpm_pkg::cell_ctl_t                 ctl_o,
  output logic [IDX_W-1:0]                   sel_o,
  output logic                               out_valid_o,
  output logic signed [fpm_pkg::PROD_W-1:0]  product_o,
  output logic [fpm_pkg::DEG_W-1:0]          degree_o,
  output logic                               last_o
);
  import fpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [DEG_W-1:0]   k_q, k_d;
  logic               vld_q, vld_d;
  logic signed [PROD_W-1:0] prod_q;
  logic [DEG_W-1:0]   deg_q;
  logic               last_q;
  logic               in_fire;
  logic               room;
  logic               step;
  logic [DEG_W-1:0]   k_max;
  logic               k_end;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CNT_W'(MAX_TERMS));
  // Output register free or being drained this cycle
  assign step       = (state_q == ST_RUN) && (!vld_q || out_ready_i);
  assign k_max      = (DEG_W'(n_q) << 1) - DEG_W'(2);
  assign k_end      = (k_q == k_max);

  assign ctl_o.load  = in_fire && room;
  assign ctl_o.clear = (cnt_q == '0);
  assign ctl_o.step  = step;
  assign sel_o       = cnt_q[IDX_W-1:0];

  // Sequencer: load pairs, then walk the 2n-1 output coefficients
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    k_d     = k_q;
    vld_d   = vld_q;
    if (vld_q && out_ready_i) begin
      vld_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (last_term_i) begin
            n_d     = room ? cnt_q + CNT_W'(1) : cnt_q;
            cnt_d   = '0;
            k_d     = '0;
            state_d = ST_RUN;
          end else if (room) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_RUN: begin
        if (step) begin
          vld_d = 1'b1;
          k_d   = k_q + DEG_W'(1);
          if (k_end) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      k_q     <= k_d;
      vld_q   <= vld_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      prod_q <= sum_i;
      deg_q  <= k_q;
      last_q <= k_end;
    end
  end

  assign out_valid_o = vld_q;
  assign product_o   = prod_q;
  assign degree_o    = deg_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/fft_polynomial_multiplier_unit.sv =====
// Polynomial multiplier: a run of n coefficient pairs is loaded one transfer per cycle,
// then a chain of MAX_TERMS multiply-add cells produces the 2n-1 exact product
// coefficients, one per cycle while the output side accepts them.
// The first result is registered after the sequencer enters its run state on last_term.
// A new run is accepted only once the last one is stepped out, set by the single result tap.
// Reset (async, active low) clears the sequencer and the output valid; cell data needs none.
module fft_polynomial_multiplier_unit #(
  parameter int MAX_TERMS  = fpm_pkg::DEF_MAX_TERMS,
  parameter int COEF_BITS  = fpm_pkg::DEF_COEF_BITS,
  parameter int IN_TDATA_W = ((2 * COEF_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,  // coef_a, coef_b, zero fill
  input  logic                              s_axis_tlast,  // last_term
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fpm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // product_coef, degree, zero fill
  output logic                              m_axis_tlast   // last_coef
);
  import fpm_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  cell_ctl_t                   ctl;
  logic [IDX_W-1:0]            sel;
  logic signed [COEF_BITS-1:0] coef_a;
  logic signed [COEF_BITS-1:0] coef_b;
  logic signed [COEF_BITS-1:0] b_link [MAX_TERMS+1];
  logic signed [PROD_W-1:0]    s_link [MAX_TERMS+1];
  logic signed [PROD_W-1:0]    sum_link [MAX_TERMS];
  logic signed [PROD_W-1:0]    product;
  logic [DEG_W-1:0]            degree;

  // Unpack input transfer
  assign coef_a = s_axis_tdata[COEF_BITS-1:0];
  assign coef_b = s_axis_tdata[2*COEF_BITS-1:COEF_BITS];

  // Chain ends feed zeros
  assign b_link[MAX_TERMS] = '0;
  assign s_link[MAX_TERMS] = '0;

  // Row of multiply-add cells; every cell reads the b term shifted into cell 0
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    fpm_cell #(
      .COEF_BITS (COEF_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .sel_i    (sel == IDX_W'(i)),
      .coef_a_i (coef_a),
      .coef_b_i (coef_b),
      .x_i      (b_link[0]),
      .b_next_i (b_link[i+1]),
      .s_next_i (s_link[i+1]),
      .b_o      (b_link[i]),
      .s_o      (s_link[i]),
      .sum_o    (sum_link[i])
    );
  end

  // Sequencer and result register
  fpm_ctrl #(
    .MAX_TERMS (MAX_TERMS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .last_term_i (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .sum_i       (sum_link[0]),
    .ctl_o       (ctl),
    .sel_o       (sel),
    .out_valid_o (m_axis_tvalid),
    .product_o   (product),
    .degree_o    (degree),
    .last_o      (m_axis_tlast)
  );

  // Pack output transfer
  assign m_axis_tdata = {{(OUT_TDATA_W - PROD_W - DEG_W){1'b0}}, degree, product};

endmodule
